// ----- sv/ghash_tag_accumulator_assert.svh -----
// Assertion macros shared by the GHASH tag accumulator checker.
// Depends on nothing; included by the checker file.
`ifndef GHASH_TAG_ACCUMULATOR_ASSERT_SVH
`define GHASH_TAG_ACCUMULATOR_ASSERT_SVH

// Concurrent assertion that is switched off while reset is high.
`define GHASH_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent assertion that is checked during reset as well.
`define GHASH_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/ghash_pkg.sv -----
// Package of the GHASH tag accumulator: widths, action codes and register indexes.
// Used by the channel interfaces, the field multiplier, the top level and the checker.
package ghash_pkg;

   localparam int WORD_WIDTH        = 64;
   localparam int BLOCK_WIDTH       = 128;
   localparam int BLOCK_BYTES       = 16;
   localparam int VALID_BYTES_WIDTH = 5;
   localparam int CSR_INDEX_WIDTH   = 1;
   localparam int CSR_DATA_WIDTH    = 64;

   typedef enum logic [1:0] {
      ACTION_AAD    = 2'd0,
      ACTION_TEXT   = 2'd1,
      ACTION_FINISH = 2'd2
   } action_type;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_H_HIGH = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_H_LOW  = 1'b1;

   localparam logic [VALID_BYTES_WIDTH-1:0] FULL_BLOCK_BYTES = 5'd16;

endpackage

// ----- sv/ghash_if.sv -----
// Valid/ready channel interfaces of the GHASH tag accumulator.
// Depends on ghash_pkg for the field widths.
interface ghash_req_if;
   import ghash_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [1:0]                   action;
   logic [WORD_WIDTH-1:0]        block_high;
   logic [WORD_WIDTH-1:0]        block_low;
   logic [VALID_BYTES_WIDTH-1:0] valid_bytes;

   modport source (output valid, action, block_high, block_low, valid_bytes, input ready);
   modport sink (input valid, action, block_high, block_low, valid_bytes, output ready);
endinterface

interface ghash_rsp_if;
   import ghash_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [WORD_WIDTH-1:0] tag_high;
   logic [WORD_WIDTH-1:0] tag_low;

   modport source (output valid, tag_high, tag_low, input ready);
   modport sink (input valid, tag_high, tag_low, output ready);
endinterface

// ----- sv/ghash_gfmul.sv -----
// Combinational GF(2^128) multiplier in GCM bit order, polynomial x^128+x^7+x^2+x+1.
// Depends on ghash_pkg for the block width.
module ghash_gfmul (
   input  logic [ghash_pkg::BLOCK_WIDTH-1:0] x_in,
   input  logic [ghash_pkg::BLOCK_WIDTH-1:0] h_in,
   output logic [ghash_pkg::BLOCK_WIDTH-1:0] z_out
);
   import ghash_pkg::*;

   localparam int PROD_WIDTH = 2 * BLOCK_WIDTH - 1;
   localparam int HIGH_WIDTH = PROD_WIDTH - BLOCK_WIDTH;
   localparam int FOLD_WIDTH = BLOCK_WIDTH + 6;

   logic [BLOCK_WIDTH-1:0] a_poly;
   logic [BLOCK_WIDTH-1:0] b_poly;
   logic [PROD_WIDTH-1:0]  prod;
   logic [HIGH_WIDTH-1:0]  prod_high;
   logic [FOLD_WIDTH-1:0]  fold;
   logic [5:0]             fold_high;
   logic [BLOCK_WIDTH-1:0] reduced;

   // GCM puts the x^0 coefficient in the most significant bit, so the
   // operands are bit-reversed into ordinary polynomial order first.
   always_comb begin
      for (int i = 0; i < BLOCK_WIDTH; i++) begin
         a_poly[i] = x_in[BLOCK_WIDTH-1-i];
         b_poly[i] = h_in[BLOCK_WIDTH-1-i];
      end
   end

   // Carry-less product: every product bit is an independent XOR tree.
   always_comb begin
      prod = '0;
      for (int i = 0; i < BLOCK_WIDTH; i++) begin
         for (int j = 0; j < BLOCK_WIDTH; j++) begin
            prod[i+j] = prod[i+j] ^ (a_poly[i] & b_poly[j]);
         end
      end
   end

   // Two folds with x^128 = x^7 + x^2 + x + 1; the second one only sees
   // the six bits that the x^7 and x^2 terms push past bit 127.
   always_comb begin
      prod_high = prod[PROD_WIDTH-1:BLOCK_WIDTH];
      fold = {6'b0, prod[BLOCK_WIDTH-1:0]}
           ^ {7'b0, prod_high}
           ^ {6'b0, prod_high, 1'b0}
           ^ {5'b0, prod_high, 2'b0}
           ^ {prod_high, 7'b0};
      fold_high = fold[FOLD_WIDTH-1:BLOCK_WIDTH];
      reduced = fold[BLOCK_WIDTH-1:0]
              ^ {122'b0, fold_high}
              ^ {121'b0, fold_high, 1'b0}
              ^ {120'b0, fold_high, 2'b0}
              ^ {115'b0, fold_high, 7'b0};
      for (int i = 0; i < BLOCK_WIDTH; i++) begin
         z_out[BLOCK_WIDTH-1-i] = reduced[i];
      end
   end

endmodule

// ----- sv/ghash_tag_accumulator.sv -----
// GHASH tag accumulator for AES-GCM.
// Channels: req_chan carries one 128-bit additional-data block, ciphertext block
// or finish command per transfer; rsp_chan carries one 128-bit tag per finish.
// The csr_ port writes the hash key halves; the user writes them only while the
// block is idle, which the block does not enforce. A data block keeps its leading
// valid_bytes bytes, is XORed into the accumulator and multiplied by the hash
// key. Finish folds in the length block, XORs the block supplied with it (the
// encrypted first counter block) and emits the tag, then clears the accumulator
// and both byte counts.
// Throughput: one item per cycle, set by the combinational field multiply in the
// accumulator feedback loop, while no finish waits on a stalled tag.
// A finish waits in the input register; its tag is then registered at the output.
// Reset clears the key, the accumulator, the counts and both valid flags.
// When the receiver stalls, the tag is held in the output register; data
// blocks keep flowing, and a following finish waits in the input register,
// which drops req_chan.ready until the output register frees up.
// Depends on ghash_pkg, ghash_if and ghash_gfmul.
module ghash_tag_accumulator #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [ghash_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ghash_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   ghash_req_if.sink                             req_chan,
   ghash_rsp_if.source                           rsp_chan
);
   import ghash_pkg::*;

   localparam int LEN_PAD = WORD_WIDTH - COUNT_WIDTH - 3;

   logic [BLOCK_WIDTH-1:0]       key_h_ff;
   logic [BLOCK_WIDTH-1:0]       key_h_in;
   logic [BLOCK_WIDTH-1:0]       acc_ff;
   logic [BLOCK_WIDTH-1:0]       acc_in;
   logic [COUNT_WIDTH-1:0]       aad_count_ff;
   logic [COUNT_WIDTH-1:0]       aad_count_in;
   logic [COUNT_WIDTH-1:0]       text_count_ff;
   logic [COUNT_WIDTH-1:0]       text_count_in;

   logic                         s1_valid_ff;
   logic                         s1_valid_in;
   logic [1:0]                   s1_action_ff;
   logic [BLOCK_WIDTH-1:0]       s1_block_ff;
   logic [VALID_BYTES_WIDTH-1:0] s1_valid_bytes_ff;

   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic [BLOCK_WIDTH-1:0]       rsp_tag_ff;
   logic [BLOCK_WIDTH-1:0]       rsp_tag_in;

   logic [VALID_BYTES_WIDTH-1:0] bytes_sat;
   logic [BLOCK_WIDTH-1:0]       byte_mask;
   logic [BLOCK_WIDTH-1:0]       len_block;
   logic [BLOCK_WIDTH-1:0]       mul_x;
   logic [BLOCK_WIDTH-1:0]       mul_z;
   logic                         is_data;
   logic                         is_finish;
   logic                         out_free;
   logic                         advance;
   logic                         req_xfer;

   // Configuration writes.
   always_comb begin
      key_h_in = key_h_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_KEY_H_HIGH: key_h_in[BLOCK_WIDTH-1:WORD_WIDTH] = csr_write_data;
            CSR_KEY_H_LOW:  key_h_in[WORD_WIDTH-1:0] = csr_write_data;
            default:        key_h_in = key_h_ff;
         endcase
      end
   end

   // Stage one: decode the held item and run it through the multiplier.
   always_comb begin
      bytes_sat = (s1_valid_bytes_ff > FULL_BLOCK_BYTES) ? FULL_BLOCK_BYTES
                                                         : s1_valid_bytes_ff;
      for (int j = 0; j < BLOCK_BYTES; j++) begin
         byte_mask[BLOCK_WIDTH-1-8*j -: 8] = {8{VALID_BYTES_WIDTH'(j) < bytes_sat}};
      end
      len_block = {{LEN_PAD{1'b0}}, aad_count_ff, 3'b000,
                   {LEN_PAD{1'b0}}, text_count_ff, 3'b000};

      // A data block with no valid bytes and the unused action code are dropped.
      is_data = s1_valid_ff && (s1_valid_bytes_ff != '0)
             && (s1_action_ff == ACTION_AAD || s1_action_ff == ACTION_TEXT);
      is_finish = s1_valid_ff && (s1_action_ff == ACTION_FINISH);

      mul_x = is_finish ? (acc_ff ^ len_block) : (acc_ff ^ (s1_block_ff & byte_mask));

      out_free = !rsp_valid_ff || rsp_chan.ready;
      advance = s1_valid_ff && (!is_finish || out_free);
      req_chan.ready = !s1_valid_ff || advance;
      req_xfer = req_chan.valid && req_chan.ready;
   end

   ghash_gfmul u_gfmul (
      .x_in  (mul_x),
      .h_in  (key_h_ff),
      .z_out (mul_z)
   );

   // Accumulator, counts and result register updates.
   always_comb begin
      acc_in = acc_ff;
      aad_count_in = aad_count_ff;
      text_count_in = text_count_ff;
      if (advance && is_data) begin
         acc_in = mul_z;
         if (s1_action_ff == ACTION_AAD) begin
            aad_count_in = aad_count_ff + COUNT_WIDTH'(bytes_sat);
         end else begin
            text_count_in = text_count_ff + COUNT_WIDTH'(bytes_sat);
         end
      end else if (advance && is_finish) begin
         acc_in = '0;
         aad_count_in = '0;
         text_count_in = '0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_tag_in = rsp_tag_ff;
      if (out_free) begin
         rsp_valid_in = advance && is_finish;
         rsp_tag_in = mul_z ^ s1_block_ff;
      end

      s1_valid_in = req_chan.ready ? req_chan.valid : s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_h_ff <= '0;
         acc_ff <= '0;
         aad_count_ff <= '0;
         text_count_ff <= '0;
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_h_ff <= key_h_in;
         acc_ff <= acc_in;
         aad_count_ff <= aad_count_in;
         text_count_ff <= text_count_in;
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_action_ff <= req_chan.action;
         s1_block_ff <= {req_chan.block_high, req_chan.block_low};
         s1_valid_bytes_ff <= req_chan.valid_bytes;
      end
      rsp_tag_ff <= rsp_tag_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.tag_high = rsp_tag_ff[BLOCK_WIDTH-1:WORD_WIDTH];
   assign rsp_chan.tag_low = rsp_tag_ff[WORD_WIDTH-1:0];

endmodule

// ----- sv/ghash_checker.sv -----
// Port-level checker of the GHASH tag accumulator and the bind that attaches it.
// Depends on ghash_pkg, ghash_if and the assertion macro header.
`include "ghash_tag_accumulator_assert.svh"

module ghash_checker (
   input logic       clock,
   input logic       reset,
   ghash_req_if.sink req_chan,
   ghash_rsp_if.source rsp_chan
);
   import ghash_pkg::*;

   logic                   finish_xfer;
   logic                   rsp_stall;
   logic [BLOCK_WIDTH-1:0] rsp_tag;

   assign finish_xfer = req_chan.valid && req_chan.ready && req_chan.action == ACTION_FINISH;
   assign rsp_stall = rsp_chan.valid && !rsp_chan.ready;
   assign rsp_tag = {rsp_chan.tag_high, rsp_chan.tag_low};

   `GHASH_ASSERT(a_rsp_valid_holds, clock, reset, rsp_stall |=> rsp_chan.valid, "tag dropped")
   `GHASH_ASSERT(a_rsp_tag_holds, clock, reset, rsp_stall |=> $stable(rsp_tag), "tag changed")
   `GHASH_ASSERT(a_tag_follows_finish, clock, reset, $rose(rsp_chan.valid) |-> $past(finish_xfer, 2), "tag without finish")
   `GHASH_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_chan.valid, "tag valid after reset")

endmodule

bind ghash_tag_accumulator ghash_checker u_ghash_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);

// ----- bench/tb_ghash_tag_accumulator.sv -----
// Self-checking bench for the GHASH tag accumulator: directed and random messages
// under random sender bursts and receiver stalls, with an in-bench GF(2^128) model.
// Depends on ghash_pkg, ghash_if and the ghash_tag_accumulator RTL.
module tb_ghash_tag_accumulator;
   timeunit 1ns;
   timeprecision 1ps;

   import ghash_pkg::*;

   localparam int COUNT_BITS = 32;
   localparam int RANDOM_ITEMS_PER_PHASE = 236;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [1:0] ACTION_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]                   action;
      logic [WORD_WIDTH-1:0]        high;
      logic [WORD_WIDTH-1:0]        low;
      logic [VALID_BYTES_WIDTH-1:0] nbytes;
   } ghash_item_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] high;
      logic [WORD_WIDTH-1:0] low;
   } tag_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data = '0;

   logic                         req_valid = 1'b0;
   logic [1:0]                   req_action = ACTION_AAD;
   logic [WORD_WIDTH-1:0]        req_high = '0;
   logic [WORD_WIDTH-1:0]        req_low = '0;
   logic [VALID_BYTES_WIDTH-1:0] req_nbytes = '0;
   logic                         req_taken = 1'b0;
   logic                         rsp_ready = 1'b0;

   ghash_req_if req_chan();
   ghash_rsp_if rsp_chan();

   assign req_chan.valid       = req_valid;
   assign req_chan.action      = req_action;
   assign req_chan.block_high  = req_high;
   assign req_chan.block_low   = req_low;
   assign req_chan.valid_bytes = req_nbytes;
   assign rsp_chan.ready       = rsp_ready;

   ghash_tag_accumulator #(
      .COUNT_WIDTH(COUNT_BITS)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_chan        (req_chan),
      .rsp_chan        (rsp_chan)
   );

   always #2 clock = ~clock;

   // Model state.
   logic [BLOCK_WIDTH-1:0] gf_key = '0;
   logic [BLOCK_WIDTH-1:0] ghash_acc = '0;
   logic [COUNT_BITS-1:0]  aad_bytes = '0;
   logic [COUNT_BITS-1:0]  text_bytes = '0;

   ghash_item_type pending_blocks[$];
   tag_type        expected_tags[$];
   int             tag_errors = 0;

   int burst_left = 0;
   int gap_left = 0;
   int ready_hold = 0;

   // GCM bit order: bit 0 of the field element is the MSB of the 128-bit vector.
   function automatic logic [BLOCK_WIDTH-1:0] gf128_mul(logic [BLOCK_WIDTH-1:0] x,
                                                        logic [BLOCK_WIDTH-1:0] h);
      logic [BLOCK_WIDTH-1:0] z;
      logic [BLOCK_WIDTH-1:0] v;
      logic                   lsb;
      z = '0;
      v = h;
      for (int i = 0; i < BLOCK_WIDTH; i++) begin
         if (x[BLOCK_WIDTH-1-i]) begin
            z ^= v;
         end
         lsb = v[0];
         v = v >> 1;
         if (lsb) begin
            v[BLOCK_WIDTH-1 -: 8] ^= 8'hE1;
         end
      end
      return z;
   endfunction

   function automatic void ghash_update(ghash_item_type item);
      logic [BLOCK_WIDTH-1:0] keep;
      int                     n;
      tag_type                tag;
      if (item.action == ACTION_AAD || item.action == ACTION_TEXT) begin
         n = item.nbytes;
         if (n == 0) begin
            return;
         end
         if (n > BLOCK_BYTES) begin
            n = BLOCK_BYTES;
         end
         keep = ~'0 << (8 * (BLOCK_BYTES - n));
         ghash_acc = gf128_mul(ghash_acc ^ ({item.high, item.low} & keep), gf_key);
         if (item.action == ACTION_AAD) begin
            aad_bytes += COUNT_BITS'(n);
         end else begin
            text_bytes += COUNT_BITS'(n);
         end
      end else if (item.action == ACTION_FINISH) begin
         ghash_acc ^= {WORD_WIDTH'(aad_bytes) << 3, WORD_WIDTH'(text_bytes) << 3};
         ghash_acc = gf128_mul(ghash_acc, gf_key);
         tag = ghash_acc ^ {item.high, item.low};
         expected_tags.push_back(tag);
         ghash_acc = '0;
         aad_bytes = '0;
         text_bytes = '0;
      end
   endfunction

   // Request driver: bursts of random length separated by random gaps.
   always @(negedge clock) begin
      ghash_item_type item;
      if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_blocks.size() > 0) begin
            item = pending_blocks.pop_front();
            req_valid <= 1'b1;
            req_action <= item.action;
            req_high <= item.high;
            req_low <= item.low;
            req_nbytes <= item.nbytes;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Tag receiver: mostly short stalls, now and then a long one to back up finishes.
   always @(negedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         rsp_ready <= !rsp_ready;
         if (rsp_ready) begin
            ready_hold <= ($urandom_range(0, 7) == 0) ? $urandom_range(6, 20)
                                                      : $urandom_range(0, 2);
         end else begin
            ready_hold <= $urandom_range(0, 12);
         end
      end
   end

   // Monitor: every request transfer updates the model, every tag transfer is checked.
   always @(posedge clock) begin
      ghash_item_type item;
      tag_type        want;
      req_taken <= req_chan.valid && req_chan.ready;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            item.action = req_chan.action;
            item.high = req_chan.block_high;
            item.low = req_chan.block_low;
            item.nbytes = req_chan.valid_bytes;
            ghash_update(item);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_tags.size() == 0) begin
               $display("%0t: unexpected tag %h_%h", $time, rsp_chan.tag_high,
                        rsp_chan.tag_low);
               tag_errors++;
            end else begin
               want = expected_tags.pop_front();
               if (rsp_chan.tag_high !== want.high) begin
                  $display("%0t: tag_high expected %h got %h", $time, want.high,
                           rsp_chan.tag_high);
                  tag_errors++;
               end
               if (rsp_chan.tag_low !== want.low) begin
                  $display("%0t: tag_low expected %h got %h", $time, want.low,
                           rsp_chan.tag_low);
                  tag_errors++;
               end
            end
         end
      end
   end

   function automatic logic [WORD_WIDTH-1:0] rand_word();
      unique case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic queue_block(logic [1:0] action, logic [WORD_WIDTH-1:0] high,
                              logic [WORD_WIDTH-1:0] low, int nbytes);
      ghash_item_type item;
      item.action = action;
      item.high = high;
      item.low = low;
      item.nbytes = VALID_BYTES_WIDTH'(nbytes);
      pending_blocks.push_back(item);
   endtask

   // A well-formed message: full blocks with a possibly short last block per section,
   // sometimes preceded by a stray item. Ignored items are not counted.
   task automatic queue_message(inout int counted);
      int          aad_blocks;
      int          text_blocks;
      int          n;
      logic [1:0]  stray_action;
      int          stray_bytes;
      aad_blocks = $urandom_range(0, 3);
      text_blocks = $urandom_range(0, 6);
      if ($urandom_range(0, 7) == 0) begin
         stray_action = 2'($urandom_range(0, 3));
         stray_bytes = $urandom_range(0, 31);
         queue_block(stray_action, rand_word(), rand_word(), stray_bytes);
         if (stray_action != ACTION_UNUSED && !(stray_action != ACTION_FINISH
                                                && stray_bytes == 0)) begin
            counted++;
         end
      end
      for (int i = 0; i < aad_blocks + text_blocks; i++) begin
         n = FULL_BLOCK_BYTES;
         if ((i == aad_blocks - 1 || i == aad_blocks + text_blocks - 1)
             && $urandom_range(0, 1) == 0) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 31) : $urandom_range(1, 16);
         end
         queue_block((i < aad_blocks) ? ACTION_AAD : ACTION_TEXT, rand_word(), rand_word(), n);
         counted++;
      end
      queue_block(ACTION_FINISH, rand_word(), rand_word(), $urandom_range(0, 31));
      counted++;
   endtask

   task automatic write_key(logic [BLOCK_WIDTH-1:0] key);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_KEY_H_HIGH;
      csr_write_data <= key[BLOCK_WIDTH-1 -: WORD_WIDTH];
      @(negedge clock);
      csr_index <= CSR_KEY_H_LOW;
      csr_write_data <= key[WORD_WIDTH-1:0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
      gf_key = key;
   endtask

   // Wait until every queued block is sent and every tag is back, then let the
   // pipeline settle so that a key write cannot overlap a late data block.
   task automatic drain();
      while (pending_blocks.size() != 0 || req_valid || expected_tags.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [BLOCK_WIDTH-1:0] phase_keys[$];
      int                     counted;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_key({$urandom, $urandom, $urandom, $urandom});
      // Field extremes and short blocks, then an empty message.
      queue_block(ACTION_AAD, '1, '1, 16);
      queue_block(ACTION_AAD, '1, '1, 1);
      queue_block(ACTION_TEXT, '0, '0, 16);
      queue_block(ACTION_TEXT, '1, '1, 15);
      queue_block(ACTION_TEXT, '1, '1, 8);
      queue_block(ACTION_TEXT, '1, '1, 9);
      queue_block(ACTION_FINISH, '0, '0, 0);
      queue_block(ACTION_FINISH, '1, '1, 31);
      // Zero byte counts and the unused action are ignored; oversized counts saturate.
      queue_block(ACTION_AAD, '1, '1, 0);
      queue_block(ACTION_TEXT, '1, '1, 0);
      queue_block(ACTION_UNUSED, '1, '1, 16);
      queue_block(ACTION_AAD, {$urandom, $urandom}, {$urandom, $urandom}, 31);
      queue_block(ACTION_TEXT, {$urandom, $urandom}, {$urandom, $urandom}, 17);
      queue_block(ACTION_FINISH, {$urandom, $urandom}, {$urandom, $urandom}, 16);
      // A short block in the middle of a section is hashed as given.
      queue_block(ACTION_AAD, {$urandom, $urandom}, {$urandom, $urandom}, 5);
      queue_block(ACTION_AAD, {$urandom, $urandom}, {$urandom, $urandom}, 16);
      queue_block(ACTION_TEXT, {$urandom, $urandom}, {$urandom, $urandom}, 16);
      queue_block(ACTION_FINISH, {$urandom, $urandom}, {$urandom, $urandom}, 7);
      drain();

      phase_keys.push_back('0);
      phase_keys.push_back('1);
      phase_keys.push_back({64'h8000_0000_0000_0000, 64'h0});
      phase_keys.push_back({64'h0, 64'h1});
      repeat (3) phase_keys.push_back({$urandom, $urandom, $urandom, $urandom});
      foreach (phase_keys[p]) begin
         write_key(phase_keys[p]);
         counted = 0;
         while (counted < RANDOM_ITEMS_PER_PHASE) begin
            queue_message(counted);
         end
         drain();
      end

      if (tag_errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+sv
sv/ghash_pkg.sv
sv/ghash_if.sv
sv/ghash_gfmul.sv
sv/ghash_tag_accumulator.sv
sv/ghash_checker.sv
bench/tb_ghash_tag_accumulator.sv
